// ===== hw/rtl/x25519_pkg.sv =====
package x25519_pkg;

    localparam int WORD_W      = 64;
    localparam int WORD_COUNT  = 4;
    localparam int IDX_W       = $clog2(WORD_COUNT);
    localparam int SC_W        = WORD_W * WORD_COUNT;
    localparam int SCALAR_BITS = 256;
    localparam int BIT_W       = $clog2(SC_W);
    localparam int FE_W        = 255;
    localparam int V_W         = 2 * SC_W;
    localparam int LIMB_W      = 32;
    localparam int LIMBS       = SC_W / LIMB_W;
    localparam int LI_W        = $clog2(LIMBS);
    localparam int SH_W        = LI_W + 1;
    localparam int FOLD_W      = V_W - FE_W + 6;
    localparam int INV_TOP     = FE_W - 1;
    localparam int REG_COUNT   = 19;
    localparam int PREG_W      = $clog2(REG_COUNT);
    localparam int PC_W        = 5;
    localparam int A24         = 121665;

    // p = 2^255 - 19
    localparam logic [SC_W-1:0] P_FULL = {1'b0, {250{1'b1}}, 5'b01101};

    typedef logic [FE_W-1:0]   t_fe;
    typedef logic [PREG_W-1:0] t_preg;

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_MOV, OP_LDP, OP_LD1, OP_LDA
    } t_op;

    typedef enum logic [1:0] {ALU_MUL, ALU_ADD, ALU_SUB, ALU_RED} t_alu_op;

    typedef enum logic [2:0] {A_IDLE, A_MAC, A_DRAIN, A_FOLD, A_CSUB} t_alu_state;

    // physical registers first, then names resolved by ladder mode
    typedef enum logic [4:0] {
        L_X1, L_X, L_Z, L_XA, L_ZA, L_NX, L_NZ, L_NXA, L_NZA,
        L_M, L_N, L_O, L_T, L_S, L_D, L_U, L_V, L_K, L_ACC,
        L_PX, L_PZ, L_DX, L_DZ, L_AX, L_AZ
    } t_lreg;

    typedef enum logic [1:0] {M_INIT, M_BIT0, M_BIT1} t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_INIT, S_IDBL, S_LADD, S_LDBL, S_LMOV,
        S_INV1, S_SQR, S_MULZ, S_FIN, S_OUT
    } t_state;

    typedef enum logic [1:0] {ST_READ, ST_START, ST_WAIT} t_step;

    typedef struct packed {
        t_op   op;
        t_lreg dst;
        t_lreg sa;
        t_lreg sb;
        logic  last;
    } t_uop;

    typedef struct packed {
        t_preg            ra;
        t_preg            rb;
        t_preg            wa;
        t_op              op;
        logic             start;
        logic             we;
        logic             res_load;
        logic             res_clear;
        logic [BIT_W-1:0] bit_idx;
        logic [IDX_W-1:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic alu_done;
        logic scalar_bit;
    } t_stat;

    localparam logic [PC_W-1:0] PC_INIT = 5'd0;
    localparam logic [PC_W-1:0] PC_DBL  = 5'd4;
    localparam logic [PC_W-1:0] PC_ADD  = 5'd13;
    localparam logic [PC_W-1:0] PC_MOV  = 5'd24;
    localparam logic [PC_W-1:0] PC_INV1 = 5'd28;
    localparam logic [PC_W-1:0] PC_SQR  = 5'd29;
    localparam logic [PC_W-1:0] PC_MULZ = 5'd30;
    localparam logic [PC_W-1:0] PC_FIN  = 5'd31;

    function automatic t_uop mk(input t_op op, input t_lreg dst, input t_lreg sa,
                                input t_lreg sb, input logic last);
        t_uop u;
        u.op = op; u.dst = dst; u.sa = sa; u.sb = sb; u.last = last;
        return u;
    endfunction

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // setup
            5'd0:  u = mk(OP_LDP, L_X1,  L_X1,  L_X1,  1'b0);
            5'd1:  u = mk(OP_LD1, L_Z,   L_X1,  L_X1,  1'b0);
            5'd2:  u = mk(OP_MOV, L_X,   L_X1,  L_X1,  1'b0);
            5'd3:  u = mk(OP_LDA, L_K,   L_X1,  L_X1,  1'b1);
            // doubling
            5'd4:  u = mk(OP_ADD, L_M,   L_PX,  L_PZ,  1'b0);
            5'd5:  u = mk(OP_MUL, L_M,   L_M,   L_M,   1'b0);
            5'd6:  u = mk(OP_SUB, L_N,   L_PX,  L_PZ,  1'b0);
            5'd7:  u = mk(OP_MUL, L_N,   L_N,   L_N,   1'b0);
            5'd8:  u = mk(OP_SUB, L_O,   L_M,   L_N,   1'b0);
            5'd9:  u = mk(OP_MUL, L_DX,  L_N,   L_M,   1'b0);
            5'd10: u = mk(OP_MUL, L_T,   L_O,   L_K,   1'b0);
            5'd11: u = mk(OP_ADD, L_T,   L_T,   L_M,   1'b0);
            5'd12: u = mk(OP_MUL, L_DZ,  L_T,   L_O,   1'b1);
            // differential addition
            5'd13: u = mk(OP_SUB, L_D,   L_XA,  L_ZA,  1'b0);
            5'd14: u = mk(OP_ADD, L_S,   L_X,   L_Z,   1'b0);
            5'd15: u = mk(OP_MUL, L_U,   L_D,   L_S,   1'b0);
            5'd16: u = mk(OP_ADD, L_S,   L_XA,  L_ZA,  1'b0);
            5'd17: u = mk(OP_SUB, L_D,   L_X,   L_Z,   1'b0);
            5'd18: u = mk(OP_MUL, L_V,   L_S,   L_D,   1'b0);
            5'd19: u = mk(OP_ADD, L_T,   L_U,   L_V,   1'b0);
            5'd20: u = mk(OP_MUL, L_AX,  L_T,   L_T,   1'b0);
            5'd21: u = mk(OP_SUB, L_T,   L_U,   L_V,   1'b0);
            5'd22: u = mk(OP_MUL, L_T,   L_T,   L_T,   1'b0);
            5'd23: u = mk(OP_MUL, L_AZ,  L_T,   L_X1,  1'b1);
            // commit new ladder state
            5'd24: u = mk(OP_MOV, L_X,   L_NX,  L_NX,  1'b0);
            5'd25: u = mk(OP_MOV, L_Z,   L_NZ,  L_NZ,  1'b0);
            5'd26: u = mk(OP_MOV, L_XA,  L_NXA, L_NXA, 1'b0);
            5'd27: u = mk(OP_MOV, L_ZA,  L_NZA, L_NZA, 1'b1);
            // inversion and final product
            5'd28: u = mk(OP_LD1, L_ACC, L_X1,  L_X1,  1'b1);
            5'd29: u = mk(OP_MUL, L_ACC, L_ACC, L_ACC, 1'b1);
            5'd30: u = mk(OP_MUL, L_ACC, L_ACC, L_Z,   1'b1);
            5'd31: u = mk(OP_MUL, L_X,   L_X,   L_ACC, 1'b1);
            default: u = mk(OP_MOV, L_X, L_X, L_X, 1'b1);
        endcase
        return u;
    endfunction

    function automatic t_preg map_reg(input t_lreg r, input t_mode m);
        t_lreg p;
        p = r;
        case (r)
            L_PX: p = (m == M_BIT1) ? L_XA : L_X;
            L_PZ: p = (m == M_BIT1) ? L_ZA : L_Z;
            L_DX: p = (m == M_INIT) ? L_XA : ((m == M_BIT1) ? L_NXA : L_NX);
            L_DZ: p = (m == M_INIT) ? L_ZA : ((m == M_BIT1) ? L_NZA : L_NZ);
            L_AX: p = (m == M_BIT1) ? L_NX : L_NXA;
            L_AZ: p = (m == M_BIT1) ? L_NZ : L_NZA;
            default: p = r;
        endcase
        return t_preg'(p);
    endfunction

    // bits of p-2: 254..5 set, then 01011
    function automatic logic exp_bit_set(input logic [BIT_W-1:0] e);
        return (e >= BIT_W'(5)) || (e == BIT_W'(3)) || (e == BIT_W'(1)) || (e == BIT_W'(0));
    endfunction

endpackage

// ===== hw/rtl/x25519_scalar_multiply.sv =====
// ~3060 field multiplications for a full 256-bit scalar share one 32x32 multiplier, each
// going through read, start, 64 limb products, drain, 3 folds, final subtract, writeback;
// a zero scalar skips the ladder and returns zero
// throughput: one computation at a time; result words leave one per cycle unless the output
// stalls, non-last items are taken one per cycle while idle
// reset: synchronous active low, clears control only; the word stores hold garbage until written
module x25519_scalar_multiply (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [x25519_pkg::IDX_W-1:0]  i_word_index,
    input  logic [x25519_pkg::WORD_W-1:0] i_scalar_word,
    input  logic [x25519_pkg::WORD_W-1:0] i_point_word,
    input  logic                          i_last_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [x25519_pkg::IDX_W-1:0]  o_result_index,
    output logic [x25519_pkg::WORD_W-1:0] o_result_word,
    output logic                          o_result_last
);
    import x25519_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;
    logic  accept;

    assign accept = i_in_valid && !busy;

    x25519_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && i_last_word),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (o_out_valid)
    );

    x25519_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_store_we    (accept),
        .i_word_index  (i_word_index),
        .i_scalar_word (i_scalar_word),
        .i_point_word  (i_point_word),
        .o_stat        (stat),
        .o_result_word (o_result_word)
    );

    assign o_in_stall     = busy;
    assign o_result_index = cmd.out_idx;
    assign o_result_last  = (cmd.out_idx == IDX_W'(WORD_COUNT - 1));

    // no item is taken while results are pending
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // result is reduced below p, so the top bit is clear
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_last) |-> !o_result_word[WORD_W-1])
        else $error("result not reduced");

    // a result burst ends only after its last word
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(o_result_last))
        else $error("result burst cut short");

    // the alu never signals done while the result is being output
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !stat.alu_done)
        else $error("alu active during output");

endmodule

// ===== hw/rtl/x25519_alu.sv =====
module x25519_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  x25519_pkg::t_alu_op         i_op,
    input  logic [x25519_pkg::SC_W-1:0] i_a,
    input  logic [x25519_pkg::SC_W-1:0] i_b,
    output logic                        o_done,
    output x25519_pkg::t_fe             o_res
);
    import x25519_pkg::*;

    t_alu_state        r_state, n_state;
    logic              r_pv, n_pv;
    logic              r_done, n_done;
    logic [LI_W-1:0]   r_i, n_i, r_j, n_j;
    logic [SC_W-1:0]   r_a, n_a, r_b, n_b;
    logic [WORD_W-1:0] r_prod, n_prod;
    logic [SH_W-1:0]   r_sh, n_sh;
    logic [V_W-1:0]    r_v, n_v;
    logic [1:0]        r_cnt, n_cnt;
    t_fe               r_res, n_res;

    logic [LIMB_W-1:0] a_limb, b_limb;
    logic [WORD_W-1:0] mul_p;
    logic [V_W-1:0]    addend;
    logic [FOLD_W-1:0] hi_x, fold_sum;
    logic [SC_W:0]     add_sum, sub_sum, csub_diff;

    always_comb begin
        a_limb    = r_a[LIMB_W*r_i +: LIMB_W];
        b_limb    = r_b[LIMB_W*r_j +: LIMB_W];
        mul_p     = WORD_W'(a_limb) * WORD_W'(b_limb);
        addend    = V_W'(r_prod) << {r_sh, 5'b0};
        // fold bits at and above 2^255 back in with weight 19
        hi_x      = FOLD_W'(r_v[V_W-1:FE_W]);
        fold_sum  = (hi_x << 4) + (hi_x << 1) + hi_x + FOLD_W'(r_v[FE_W-1:0]);
        add_sum   = {1'b0, i_a} + {1'b0, i_b};
        sub_sum   = {1'b0, i_a} + {1'b0, P_FULL} - {1'b0, i_b};
        csub_diff = {1'b0, r_v[SC_W-1:0]} - {1'b0, P_FULL};

        n_state = r_state;
        n_pv    = r_pv;
        n_done  = 1'b0;
        n_i     = r_i;
        n_j     = r_j;
        n_a     = r_a;
        n_b     = r_b;
        n_prod  = r_prod;
        n_sh    = r_sh;
        n_v     = r_v;
        n_cnt   = r_cnt;
        n_res   = r_res;

        case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    n_a   = i_a;
                    n_b   = i_b;
                    n_cnt = 2'd0;
                    case (i_op)
                        ALU_MUL: begin
                            n_v     = '0;
                            n_i     = '0;
                            n_j     = '0;
                            n_pv    = 1'b0;
                            n_state = A_MAC;
                        end
                        ALU_ADD: begin
                            n_v     = V_W'(add_sum);
                            n_state = A_CSUB;
                        end
                        ALU_SUB: begin
                            n_v     = V_W'(sub_sum);
                            n_state = A_CSUB;
                        end
                        default: begin
                            n_v     = V_W'(i_a);
                            n_state = A_FOLD;
                        end
                    endcase
                end
            end
            A_MAC: begin
                n_prod = mul_p;
                n_sh   = {1'b0, r_i} + {1'b0, r_j};
                n_pv   = 1'b1;
                if (r_pv) begin
                    n_v = r_v + addend;
                end
                n_j = r_j + 1'b1;
                if (r_j == LI_W'(LIMBS - 1)) begin
                    n_i = r_i + 1'b1;
                    if (r_i == LI_W'(LIMBS - 1)) begin
                        n_state = A_DRAIN;
                    end
                end
            end
            A_DRAIN: begin
                n_v     = r_v + addend;
                n_pv    = 1'b0;
                n_state = A_FOLD;
            end
            A_FOLD: begin
                n_v   = V_W'(fold_sum);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 2'd2) begin
                    n_state = A_CSUB;
                end
            end
            A_CSUB: begin
                n_res   = csub_diff[SC_W] ? r_v[FE_W-1:0] : csub_diff[FE_W-1:0];
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= n_prod;
        r_sh   <= n_sh;
        r_v    <= n_v;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hw/rtl/x25519_dp.sv =====
module x25519_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  x25519_pkg::t_cmd              i_cmd,
    input  logic                          i_store_we,
    input  logic [x25519_pkg::IDX_W-1:0]  i_word_index,
    input  logic [x25519_pkg::WORD_W-1:0] i_scalar_word,
    input  logic [x25519_pkg::WORD_W-1:0] i_point_word,
    output x25519_pkg::t_stat             o_stat,
    output logic [x25519_pkg::WORD_W-1:0] o_result_word
);
    import x25519_pkg::*;

    logic [SC_W-1:0] r_scalar, r_point;
    t_fe             r_rf [REG_COUNT];
    t_fe             r_rda, r_rdb;
    t_fe             r_res;

    t_alu_op         alu_op;
    logic [SC_W-1:0] opa, opb;
    logic            alu_done;
    t_fe             alu_res;
    logic [SC_W-1:0] res_ext;

    always_comb begin
        opb = {1'b0, r_rdb};
        case (i_cmd.op)
            OP_MUL:  begin alu_op = ALU_MUL; opa = {1'b0, r_rda}; end
            OP_ADD:  begin alu_op = ALU_ADD; opa = {1'b0, r_rda}; end
            OP_SUB:  begin alu_op = ALU_SUB; opa = {1'b0, r_rda}; end
            OP_LDP:  begin alu_op = ALU_RED; opa = r_point; end
            OP_LD1:  begin alu_op = ALU_RED; opa = SC_W'(1); end
            OP_LDA:  begin alu_op = ALU_RED; opa = SC_W'(A24); end
            default: begin alu_op = ALU_RED; opa = {1'b0, r_rda}; end
        endcase
    end

    x25519_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (alu_op),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_store_we) begin
            r_scalar[WORD_W*i_word_index +: WORD_W] <= i_scalar_word;
            r_point[WORD_W*i_word_index +: WORD_W]  <= i_point_word;
        end
    end

    // field element register file, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_rf[i_cmd.wa] <= alu_res;
        end
        r_rda <= r_rf[i_cmd.ra];
        r_rdb <= r_rf[i_cmd.rb];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clear) begin
            r_res <= '0;
        end else if (i_cmd.res_load) begin
            r_res <= alu_res;
        end
    end

    assign res_ext              = {1'b0, r_res};
    assign o_result_word        = res_ext[WORD_W*i_cmd.out_idx +: WORD_W];
    assign o_stat.alu_done      = alu_done;
    assign o_stat.scalar_bit    = r_scalar[i_cmd.bit_idx];

endmodule

// ===== hw/rtl/x25519_ctrl.sv =====
module x25519_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_stall,
    input  x25519_pkg::t_stat i_stat,
    output x25519_pkg::t_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_out_valid
);
    import x25519_pkg::*;

    t_state           r_state, n_state;
    t_step            r_step, n_step;
    logic [PC_W-1:0]  r_pc, n_pc;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [IDX_W-1:0] r_oidx, n_oidx;

    t_uop  uop;
    t_mode mode;
    t_cmd  cmd;
    logic  run;
    logic  seg_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_READ;
            r_pc    <= '0;
            r_bit   <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_pc    <= n_pc;
            r_bit   <= n_bit;
            r_oidx  <= n_oidx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_pc    = r_pc;
        n_bit   = r_bit;
        n_oidx  = r_oidx;

        uop  = uop_rom(r_pc);
        mode = (r_state == S_IDBL) ? M_INIT : (i_stat.scalar_bit ? M_BIT1 : M_BIT0);
        run  = (r_state != S_IDLE) && (r_state != S_SCAN) && (r_state != S_OUT);

        cmd.ra        = map_reg(uop.sa, mode);
        cmd.rb        = map_reg(uop.sb, mode);
        cmd.wa        = map_reg(uop.dst, mode);
        cmd.op        = uop.op;
        cmd.start     = run && (r_step == ST_START);
        cmd.we        = run && (r_step == ST_WAIT) && i_stat.alu_done;
        cmd.res_load  = cmd.we && (r_state == S_FIN);
        cmd.res_clear = 1'b0;
        cmd.bit_idx   = r_bit;
        cmd.out_idx   = r_oidx;
        seg_end       = cmd.we && uop.last;

        // per-op sequencing: read operands, start unit, wait for writeback
        if (run) begin
            case (r_step)
                ST_READ:  n_step = ST_START;
                ST_START: n_step = ST_WAIT;
                ST_WAIT: begin
                    if (i_stat.alu_done) begin
                        n_step = ST_READ;
                        n_pc   = r_pc + 1'b1;
                    end
                end
                default: n_step = ST_READ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_bit   = BIT_W'(SCALAR_BITS - 1);
                end
            end
            S_SCAN: begin
                if (i_stat.scalar_bit) begin
                    n_state = S_INIT;
                    n_pc    = PC_INIT;
                    n_step  = ST_READ;
                end else if (r_bit == '0) begin
                    cmd.res_clear = 1'b1;
                    n_state       = S_OUT;
                    n_oidx        = '0;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_INIT: begin
                if (seg_end) begin
                    n_state = S_IDBL;
                    n_pc    = PC_DBL;
                end
            end
            S_IDBL, S_LMOV: begin
                if (seg_end) begin
                    if (r_bit == '0) begin
                        n_state = S_INV1;
                        n_pc    = PC_INV1;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_LADD;
                        n_pc    = PC_ADD;
                    end
                end
            end
            S_LADD: begin
                if (seg_end) begin
                    n_state = S_LDBL;
                    n_pc    = PC_DBL;
                end
            end
            S_LDBL: begin
                if (seg_end) begin
                    n_state = S_LMOV;
                    n_pc    = PC_MOV;
                end
            end
            S_INV1: begin
                if (seg_end) begin
                    n_state = S_SQR;
                    n_pc    = PC_SQR;
                    n_bit   = BIT_W'(INV_TOP);
                end
            end
            S_SQR, S_MULZ: begin
                if (seg_end) begin
                    if ((r_state == S_SQR) && exp_bit_set(r_bit)) begin
                        n_state = S_MULZ;
                        n_pc    = PC_MULZ;
                    end else if (r_bit == '0) begin
                        n_state = S_FIN;
                        n_pc    = PC_FIN;
                    end else begin
                        n_bit   = r_bit - 1'b1;
                        n_state = S_SQR;
                        n_pc    = PC_SQR;
                    end
                end
            end
            S_FIN: begin
                if (seg_end) begin
                    n_state = S_OUT;
                    n_oidx  = '0;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_oidx == IDX_W'(WORD_COUNT - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

// ===== tb/sv/x25519_scalar_multiply_tb.sv =====
module x25519_scalar_multiply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import x25519_pkg::*;

    typedef logic [SC_W-1:0] t_elem;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_out_word;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     HOLD_CYCLES = 400;

    class x25519_scoreboard;
        logic [WORD_W-1:0] scalar_w[WORD_COUNT];
        logic [WORD_W-1:0] point_w[WORD_COUNT];
        t_out_word         u_words_q[$];
        int                errors;

        function new();
            errors = 0;
            foreach (scalar_w[i]) begin
                scalar_w[i] = '0;
                point_w[i]  = '0;
            end
        endfunction

        function t_elem fmul(input t_elem a, input t_elem b);
            logic [V_W-1:0] w;
            w = {{SC_W{1'b0}}, a} * {{SC_W{1'b0}}, b};
            return t_elem'(w % {{SC_W{1'b0}}, P_FULL});
        endfunction

        function t_elem fadd(input t_elem a, input t_elem b);
            logic [SC_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, P_FULL}) s = s - {1'b0, P_FULL};
            return t_elem'(s);
        endfunction

        function t_elem fsub(input t_elem a, input t_elem b);
            return (a >= b) ? a - b : a + P_FULL - b;
        endfunction

        function void ladder_dbl(input t_elem x, input t_elem z, output t_elem xo,
                                 output t_elem zo);
            t_elem m, n, o, t;
            m = fadd(x, z);
            m = fmul(m, m);
            n = fsub(x, z);
            n = fmul(n, n);
            o = fsub(m, n);
            xo = fmul(n, m);
            t = fmul(o, t_elem'(A24));
            t = fadd(t, m);
            zo = fmul(t, o);
        endfunction

        function void ladder_sum(input t_elem x, input t_elem z, input t_elem xq,
                                 input t_elem zq, input t_elem xd, output t_elem xo,
                                 output t_elem zo);
            t_elem u, v, t;
            u = fmul(fsub(x, z), fadd(xq, zq));
            v = fmul(fadd(x, z), fsub(xq, zq));
            t = fadd(u, v);
            xo = fmul(t, t);
            t = fsub(u, v);
            t = fmul(t, t);
            zo = fmul(t, xd);
        endfunction

        function t_elem scalar_mult();
            t_elem k, x1, x, z, xa, za, nx, nz, nxa, nza, acc;
            int    n;
            k = {scalar_w[3], scalar_w[2], scalar_w[1], scalar_w[0]};
            n = SCALAR_BITS - 1;
            while (n >= 0 && !k[n]) n--;
            if (n < 0) return '0;
            x1 = {point_w[3], point_w[2], point_w[1], point_w[0]} % P_FULL;
            ladder_dbl(x1, t_elem'(1), xa, za);
            x = x1;
            z = t_elem'(1);
            for (int i = n - 1; i >= 0; i--) begin
                if (!k[i]) begin
                    ladder_dbl(x, z, nx, nz);
                    ladder_sum(xa, za, x, z, x1, nxa, nza);
                end else begin
                    ladder_sum(xa, za, x, z, x1, nx, nz);
                    ladder_dbl(xa, za, nxa, nza);
                end
                x = nx; z = nz; xa = nxa; za = nza;
            end
            // z^(p-2), zero stays zero
            acc = t_elem'(1);
            for (int i = INV_TOP; i >= 0; i--) begin
                acc = fmul(acc, acc);
                if (i >= 5 || i == 3 || i == 1 || i == 0) acc = fmul(acc, z);
            end
            return fmul(x, acc);
        endfunction

        function void note_item(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] sw,
                                input logic [WORD_W-1:0] pw, input logic last);
            t_elem     r;
            t_out_word e;
            scalar_w[idx] = sw;
            point_w[idx]  = pw;
            if (!last) return;
            r = scalar_mult();
            for (int k = 0; k < WORD_COUNT; k++) begin
                e.idx  = IDX_W'(k);
                e.word = r[k*WORD_W +: WORD_W];
                e.last = (k == WORD_COUNT - 1);
                u_words_q.push_back(e);
            end
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word,
                        input logic last);
            t_out_word e;
            if (u_words_q.size() == 0) begin
                report($sformatf("unexpected result word idx=%0d word=%h", idx, word));
                return;
            end
            e = u_words_q.pop_front();
            if (idx !== e.idx)
                report($sformatf("result_index got %0d want %0d", idx, e.idx));
            if (word !== e.word)
                report($sformatf("result_word[%0d] got %h want %h", e.idx, word, e.word));
            if (last !== e.last)
                report($sformatf("result_last[%0d] got %b want %b", e.idx, last, e.last));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [IDX_W-1:0]  i_word_index = '0;
    logic [WORD_W-1:0] i_scalar_word = '0;
    logic [WORD_W-1:0] i_point_word = '0;
    logic              i_last_word = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [IDX_W-1:0]  o_result_index;
    logic [WORD_W-1:0] o_result_word;
    logic              o_result_last;

    x25519_scalar_multiply dut (.*);

    x25519_scoreboard sb = new();
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     pressure_on = 1'b0;
    bit     pressure_done = 1'b0;
    int     hold_cnt = 0;
    longint cycles = 0;
    int     n_items = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // results are checked as they leave
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_word(o_result_index, o_result_word, o_result_last);
    end

    // receiver: random stalls, plus one long hold-off once results are waiting
    always @(negedge i_clk) begin
        if (pressure_on && !pressure_done) begin
            i_out_stall <= 1'b1;
            if (o_out_valid === 1'b1) hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) pressure_done = 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] sw,
                             input logic [WORD_W-1:0] pw, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_word_index  <= idx;
        i_scalar_word <= sw;
        i_point_word  <= pw;
        i_last_word   <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(idx, sw, pw, last);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_operands(input t_elem k, input t_elem u);
        for (int i = 0; i < WORD_COUNT; i++)
            send_item(IDX_W'(i), k[i*WORD_W +: WORD_W], u[i*WORD_W +: WORD_W],
                      i == WORD_COUNT - 1);
    endtask

    task automatic random_sequence();
        t_elem k, u;
        int    sel;
        // noise that gets overwritten below: random words at random indices
        repeat ($urandom_range(0, 2))
            send_item(IDX_W'($urandom_range(0, 3)), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'b0);
        k = '0;
        sel = $urandom_range(99);
        // mostly short scalars: ladder time grows with the top set bit
        if (sel >= 10)
            k = t_elem'({$urandom, $urandom} & ((64'd1 << $urandom_range(1, 14)) - 1));
        for (int i = 0; i < WORD_COUNT; i++) u[i*32 +: 32] = $urandom;
        for (int i = WORD_COUNT; i < 8; i++) u[i*32 +: 32] = $urandom;
        if ($urandom_range(9) == 0) u = P_FULL + t_elem'($urandom_range(0, 20));
        if ($urandom_range(99) < 15) begin
            for (int i = WORD_COUNT - 1; i >= 0; i--)
                send_item(IDX_W'(i), k[i*WORD_W +: WORD_W], u[i*WORD_W +: WORD_W], i == 0);
        end else begin
            send_operands(k, u);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        send_operands('0, '1);
        send_operands(t_elem'(1), P_FULL);
        send_operands(t_elem'(2), t_elem'(9));
        send_operands(t_elem'(3), '0);
        send_item(2'd0, 64'd5, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_item(2'd2, 64'd0, 64'd0, 1'b0);
        send_item(2'd3, 64'd0, 64'h7fff_ffff_ffff_ffff, 1'b0);
        send_item(2'd1, 64'd0, 64'hffff_ffff_ffff_ffff, 1'b1);
        // full-width scalar, point above p
        send_operands('1, '1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  pressure_on = 1'b1; end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            while (n_items < (phase + 1) * 25) random_sequence();
        end
        i_in_valid <= 1'b0;

        while (sb.u_words_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/x25519_pkg.sv
hw/rtl/x25519_alu.sv
hw/rtl/x25519_dp.sv
hw/rtl/x25519_ctrl.sv
hw/rtl/x25519_scalar_multiply.sv
tb/sv/x25519_scalar_multiply_tb.sv
